// ----- hdl/vmmio_pkg.sv -----
// shared constants for the virtio mmio register block
package vmmio_pkg;

   localparam int DEF_QUEUE_COUNT  = 2;
   localparam int DEF_QUEUE_MAX    = 256;

   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH   = 64;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEVICE_TYPE_ID     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFFERED_FEATURES   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VENDOR_CODE        = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CONFIG_SPACE_BYTES = 2'd3;

   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_RAISE = 2'd2;
   localparam logic [1:0] FUNC_NOP   = 2'd3;

   localparam logic [11:0] OFF_MAGIC          = 12'h000;
   localparam logic [11:0] OFF_VERSION        = 12'h004;
   localparam logic [11:0] OFF_DEVICE_ID      = 12'h008;
   localparam logic [11:0] OFF_VENDOR_ID      = 12'h00c;
   localparam logic [11:0] OFF_DEV_FEATURES   = 12'h010;
   localparam logic [11:0] OFF_DEV_FEAT_SEL   = 12'h014;
   localparam logic [11:0] OFF_DRV_FEATURES   = 12'h020;
   localparam logic [11:0] OFF_DRV_FEAT_SEL   = 12'h024;
   localparam logic [11:0] OFF_QUEUE_SEL      = 12'h030;
   localparam logic [11:0] OFF_QUEUE_NUM_MAX  = 12'h034;
   localparam logic [11:0] OFF_QUEUE_NUM      = 12'h038;
   localparam logic [11:0] OFF_QUEUE_READY    = 12'h044;
   localparam logic [11:0] OFF_QUEUE_NOTIFY   = 12'h050;
   localparam logic [11:0] OFF_IRQ_STATUS     = 12'h060;
   localparam logic [11:0] OFF_IRQ_ACK        = 12'h064;
   localparam logic [11:0] OFF_STATUS         = 12'h070;
   localparam logic [11:0] OFF_DESC_LOW       = 12'h080;
   localparam logic [11:0] OFF_DESC_HIGH      = 12'h084;
   localparam logic [11:0] OFF_AVAIL_LOW      = 12'h090;
   localparam logic [11:0] OFF_AVAIL_HIGH     = 12'h094;
   localparam logic [11:0] OFF_USED_LOW       = 12'h0a0;
   localparam logic [11:0] OFF_USED_HIGH      = 12'h0a4;
   localparam logic [11:0] CFG_BASE           = 12'h100;

   localparam logic [31:0] MAGIC_WORD     = 32'h7472_6976;
   localparam logic [31:0] VERSION_WORD   = 32'd2;
   localparam logic [31:0] ALL_ONES       = 32'hffff_ffff;
   localparam int          ST_DRIVER_OK   = 2;
   localparam int          ST_FEATURES_OK = 3;
   localparam logic [8:0]  CFG_MAX_BYTES  = 9'd256;
   localparam logic [3:0]  WORD_BYTES     = 4'd4;

endpackage

// ----- hdl/virtio_mmio_register_block_core.sv -----
// virtio mmio version 2 transport registers: decode, per-queue state and event outputs
//
// One request is taken in every clock cycle (busy is held low); its result appears on the
// rsp_ ports, marked by rsp_valid, in the cycle after the request is taken, set by the
// single result register behind the decode logic. The receiver cannot stall, so results
// must be consumed in the cycle they are shown. Configuration writes through the csr_ port
// take effect at the clock edge where csr_write_enable is high.
module virtio_mmio_register_block_core #(
   parameter int QUEUE_COUNT = vmmio_pkg::DEF_QUEUE_COUNT,
   parameter int QUEUE_MAX   = vmmio_pkg::DEF_QUEUE_MAX
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_func,
   input  logic [11:0]                           req_reg_offset,
   input  logic [3:0]                            req_access_bytes,
   input  logic [31:0]                           req_write_value,
   output logic                                  rsp_valid,
   output logic [31:0]                           rsp_read_value,
   output logic                                  rsp_irq_level,
   output logic                                  rsp_notify_valid,
   output logic [2:0]                            rsp_notify_queue,
   output logic                                  rsp_features_done,
   output logic [63:0]                           rsp_accepted_features,
   output logic                                  rsp_reset_pulse,
   output logic                                  rsp_config_hit,
   output logic [7:0]                            rsp_config_offset,
   input  logic                                  csr_write_enable,
   input  logic [vmmio_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [vmmio_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import vmmio_pkg::*;

   localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
   localparam int SW = $clog2(QUEUE_MAX + 1);
   localparam logic [31:0] QUEUE_COUNT_W = 32'(QUEUE_COUNT);
   localparam logic [31:0] QUEUE_MAX_W   = 32'(QUEUE_MAX);

   // configuration
   logic [7:0]  device_type_id_ff,     device_type_id_in;
   logic [63:0] offered_features_ff,   offered_features_in;
   logic [31:0] vendor_code_ff,        vendor_code_in;
   logic [8:0]  config_space_bytes_ff, config_space_bytes_in;

   // device state
   logic [31:0] device_status_ff,      device_status_in;
   logic [31:0] irq_status_ff,         irq_status_in;
   logic [31:0] dev_feature_select_ff, dev_feature_select_in;
   logic [31:0] drv_feature_select_ff, drv_feature_select_in;
   logic [63:0] driver_features_ff,    driver_features_in;
   logic [31:0] queue_select_ff,       queue_select_in;
   logic [31:0] desc_low_ff,           desc_low_in;
   logic [31:0] avail_low_ff,          avail_low_in;
   logic [31:0] used_low_ff,           used_low_in;
   logic [SW-1:0] queue_size_ff  [QUEUE_COUNT];
   logic [SW-1:0] queue_size_in  [QUEUE_COUNT];
   logic          queue_ready_ff [QUEUE_COUNT];
   logic          queue_ready_in [QUEUE_COUNT];
   logic [63:0]   queue_desc_ff  [QUEUE_COUNT];
   logic [63:0]   queue_desc_in  [QUEUE_COUNT];
   logic [63:0]   queue_avail_ff [QUEUE_COUNT];
   logic [63:0]   queue_avail_in [QUEUE_COUNT];
   logic [63:0]   queue_used_ff  [QUEUE_COUNT];
   logic [63:0]   queue_used_in  [QUEUE_COUNT];

   // result register
   logic        rsp_valid_ff,         rsp_valid_in;
   logic [31:0] read_value_ff,        read_value_in;
   logic        irq_level_ff,         irq_level_in;
   logic        notify_valid_ff,      notify_valid_in;
   logic [2:0]  notify_queue_ff,      notify_queue_in;
   logic        features_done_ff,     features_done_in;
   logic [63:0] accepted_features_ff, accepted_features_in;
   logic        reset_pulse_ff,       reset_pulse_in;
   logic        config_hit_ff,        config_hit_in;
   logic [7:0]  config_offset_ff,     config_offset_in;

   logic          accept;
   logic [8:0]    cfg_size;
   logic          in_cfg;
   logic          word_access;
   logic          qok;
   logic [QW-1:0] qidx;
   logic [31:0]   wv;
   logic [11:0]   cfg_rel;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign wv     = req_write_value;

   assign cfg_size    = (config_space_bytes_ff > CFG_MAX_BYTES) ? CFG_MAX_BYTES
                                                                 : config_space_bytes_ff;
   assign cfg_rel     = req_reg_offset - CFG_BASE;
   assign in_cfg      = (req_reg_offset >= CFG_BASE) && (cfg_rel < {3'b000, cfg_size});
   assign word_access = (req_access_bytes == WORD_BYTES);
   assign qok         = queue_select_ff < QUEUE_COUNT_W;
   assign qidx        = queue_select_ff[QW-1:0];

   always_comb begin
      device_type_id_in     = device_type_id_ff;
      offered_features_in   = offered_features_ff;
      vendor_code_in        = vendor_code_ff;
      config_space_bytes_in = config_space_bytes_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEVICE_TYPE_ID:     device_type_id_in     = csr_write_data[7:0];
            CSR_OFFERED_FEATURES:   offered_features_in   = csr_write_data;
            CSR_VENDOR_CODE:        vendor_code_in        = csr_write_data[31:0];
            CSR_CONFIG_SPACE_BYTES: config_space_bytes_in = csr_write_data[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      device_status_in      = device_status_ff;
      irq_status_in         = irq_status_ff;
      dev_feature_select_in = dev_feature_select_ff;
      drv_feature_select_in = drv_feature_select_ff;
      driver_features_in    = driver_features_ff;
      queue_select_in       = queue_select_ff;
      desc_low_in           = desc_low_ff;
      avail_low_in          = avail_low_ff;
      used_low_in           = used_low_ff;
      queue_size_in         = queue_size_ff;
      queue_ready_in        = queue_ready_ff;
      queue_desc_in         = queue_desc_ff;
      queue_avail_in        = queue_avail_ff;
      queue_used_in         = queue_used_ff;

      rsp_valid_in          = accept;
      read_value_in         = '0;
      notify_valid_in       = 1'b0;
      notify_queue_in       = '0;
      features_done_in      = 1'b0;
      accepted_features_in  = '0;
      reset_pulse_in        = 1'b0;
      config_hit_in         = 1'b0;
      config_offset_in      = '0;

      if (accept) begin
         unique case (req_func)
            FUNC_READ, FUNC_WRITE: begin
               if (in_cfg) begin
                  config_hit_in    = 1'b1;
                  config_offset_in = cfg_rel[7:0];
               end else if (word_access && req_func == FUNC_READ) begin
                  unique case (req_reg_offset)
                     OFF_MAGIC:         read_value_in = MAGIC_WORD;
                     OFF_VERSION:       read_value_in = VERSION_WORD;
                     OFF_DEVICE_ID:     read_value_in = {24'd0, device_type_id_ff};
                     OFF_VENDOR_ID:     read_value_in = vendor_code_ff;
                     OFF_DEV_FEATURES: begin
                        if (dev_feature_select_ff == 32'd0)
                           read_value_in = offered_features_ff[31:0];
                        else if (dev_feature_select_ff == 32'd1)
                           read_value_in = offered_features_ff[63:32];
                     end
                     OFF_QUEUE_NUM_MAX: read_value_in = qok ? QUEUE_MAX_W : '0;
                     OFF_QUEUE_READY:
                        read_value_in = {31'd0, qok && queue_ready_ff[qidx]};
                     OFF_IRQ_STATUS:    read_value_in = irq_status_ff;
                     OFF_STATUS:        read_value_in = device_status_ff;
                     default: ;
                  endcase
               end else if (word_access) begin
                  unique case (req_reg_offset)
                     OFF_DEV_FEAT_SEL: dev_feature_select_in = wv;
                     OFF_DRV_FEATURES: begin
                        if (drv_feature_select_ff == 32'd0)
                           driver_features_in[31:0] = wv;
                        else if (drv_feature_select_ff == 32'd1)
                           driver_features_in[63:32] = wv;
                     end
                     OFF_DRV_FEAT_SEL: drv_feature_select_in = wv;
                     OFF_QUEUE_SEL:    queue_select_in = wv;
                     OFF_QUEUE_NUM: begin
                        // power of two (or zero) no larger than the maximum
                        if (qok && wv <= QUEUE_MAX_W && (wv & (wv - 32'd1)) == 32'd0)
                           queue_size_in[qidx] = wv[SW-1:0];
                     end
                     OFF_QUEUE_READY: begin
                        if (qok) queue_ready_in[qidx] = (wv != 32'd0);
                     end
                     OFF_QUEUE_NOTIFY: begin
                        if (wv < QUEUE_COUNT_W) begin
                           notify_valid_in = 1'b1;
                           notify_queue_in = wv[2:0];
                        end
                     end
                     OFF_IRQ_ACK: irq_status_in = irq_status_ff & (wv ^ ALL_ONES);
                     OFF_STATUS: begin
                        if (wv == 32'd0) begin
                           // device reset; the address low latches survive
                           reset_pulse_in        = 1'b1;
                           device_status_in      = '0;
                           irq_status_in         = '0;
                           dev_feature_select_in = '0;
                           drv_feature_select_in = '0;
                           driver_features_in    = '0;
                           queue_select_in       = '0;
                           for (int i = 0; i < QUEUE_COUNT; i++) begin
                              queue_size_in[i]  = '0;
                              queue_ready_in[i] = 1'b0;
                              queue_desc_in[i]  = '0;
                              queue_avail_in[i] = '0;
                              queue_used_in[i]  = '0;
                           end
                        end else begin
                           device_status_in = wv;
                           if (wv[ST_FEATURES_OK] && !wv[ST_DRIVER_OK]) begin
                              features_done_in     = 1'b1;
                              accepted_features_in = driver_features_ff;
                           end
                        end
                     end
                     OFF_DESC_LOW:   if (qok) desc_low_in  = wv;
                     OFF_DESC_HIGH:  if (qok) queue_desc_in[qidx]  = {wv, desc_low_ff};
                     OFF_AVAIL_LOW:  if (qok) avail_low_in = wv;
                     OFF_AVAIL_HIGH: if (qok) queue_avail_in[qidx] = {wv, avail_low_ff};
                     OFF_USED_LOW:   if (qok) used_low_in  = wv;
                     OFF_USED_HIGH:  if (qok) queue_used_in[qidx]  = {wv, used_low_ff};
                     default: ;
                  endcase
               end
            end
            FUNC_RAISE: irq_status_in = irq_status_ff | wv;
            FUNC_NOP: ;
            default: ;
         endcase
      end

      irq_level_in = (irq_status_in != 32'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_type_id_ff     <= '0;
         offered_features_ff   <= '0;
         vendor_code_ff        <= '0;
         config_space_bytes_ff <= '0;
         device_status_ff      <= '0;
         irq_status_ff         <= '0;
         dev_feature_select_ff <= '0;
         drv_feature_select_ff <= '0;
         driver_features_ff    <= '0;
         queue_select_ff       <= '0;
         desc_low_ff           <= '0;
         avail_low_ff          <= '0;
         used_low_ff           <= '0;
         for (int i = 0; i < QUEUE_COUNT; i++) begin
            queue_size_ff[i]  <= '0;
            queue_ready_ff[i] <= 1'b0;
            queue_desc_ff[i]  <= '0;
            queue_avail_ff[i] <= '0;
            queue_used_ff[i]  <= '0;
         end
         rsp_valid_ff          <= 1'b0;
      end else begin
         device_type_id_ff     <= device_type_id_in;
         offered_features_ff   <= offered_features_in;
         vendor_code_ff        <= vendor_code_in;
         config_space_bytes_ff <= config_space_bytes_in;
         device_status_ff      <= device_status_in;
         irq_status_ff         <= irq_status_in;
         dev_feature_select_ff <= dev_feature_select_in;
         drv_feature_select_ff <= drv_feature_select_in;
         driver_features_ff    <= driver_features_in;
         queue_select_ff       <= queue_select_in;
         desc_low_ff           <= desc_low_in;
         avail_low_ff          <= avail_low_in;
         used_low_ff           <= used_low_in;
         queue_size_ff         <= queue_size_in;
         queue_ready_ff        <= queue_ready_in;
         queue_desc_ff         <= queue_desc_in;
         queue_avail_ff        <= queue_avail_in;
         queue_used_ff         <= queue_used_in;
         rsp_valid_ff          <= rsp_valid_in;
      end
   end

   // result payload, qualified by rsp_valid
   always_ff @(posedge clock) begin
      read_value_ff        <= read_value_in;
      irq_level_ff         <= irq_level_in;
      notify_valid_ff      <= notify_valid_in;
      notify_queue_ff      <= notify_queue_in;
      features_done_ff     <= features_done_in;
      accepted_features_ff <= accepted_features_in;
      reset_pulse_ff       <= reset_pulse_in;
      config_hit_ff        <= config_hit_in;
      config_offset_ff     <= config_offset_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_read_value        = read_value_ff;
   assign rsp_irq_level         = irq_level_ff;
   assign rsp_notify_valid      = notify_valid_ff;
   assign rsp_notify_queue      = notify_queue_ff;
   assign rsp_features_done     = features_done_ff;
   assign rsp_accepted_features = accepted_features_ff;
   assign rsp_reset_pulse       = reset_pulse_ff;
   assign rsp_config_hit        = config_hit_ff;
   assign rsp_config_offset     = config_offset_ff;

endmodule

// ----- tb/tb.sv -----
// testbench for the virtio mmio register block: directed and random bus traffic, checked per request
module tb;
   import vmmio_pkg::*;

   localparam int QUEUE_COUNT = DEF_QUEUE_COUNT;
   localparam int QUEUE_LIMIT = DEF_QUEUE_MAX;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_LIMIT = 64;

   localparam logic [11:0] OFF_CONFIG_GEN = 12'h0fc;
   localparam logic [11:0] OFF_UNMAPPED   = 12'hffc;

   localparam logic [31:0] STATUS_ACK     = 32'h1;
   localparam logic [31:0] STATUS_DRIVER  = 32'h2;
   localparam logic [31:0] STATUS_DRV_OK  = 32'(1) << ST_DRIVER_OK;
   localparam logic [31:0] STATUS_FEAT_OK = 32'(1) << ST_FEATURES_OK;

   typedef struct {
      logic [31:0] read_value;
      logic        irq_level;
      logic        notify_valid;
      logic [2:0]  notify_queue;
      logic        features_done;
      logic [63:0] accepted_features;
      logic        reset_pulse;
      logic        config_hit;
      logic [7:0]  config_offset;
   } mmio_response_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_func;
   logic [11:0] req_reg_offset;
   logic [3:0]  req_access_bytes;
   logic [31:0] req_write_value;
   logic        rsp_valid;
   logic [31:0] rsp_read_value;
   logic        rsp_irq_level;
   logic        rsp_notify_valid;
   logic [2:0]  rsp_notify_queue;
   logic        rsp_features_done;
   logic [63:0] rsp_accepted_features;
   logic        rsp_reset_pulse;
   logic        rsp_config_hit;
   logic [7:0]  rsp_config_offset;
   logic        csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   // device settings as last written
   logic [7:0]  type_id_setting   = '0;
   logic [63:0] feature_offer     = '0;
   logic [31:0] vendor_setting    = '0;
   logic [8:0]  cfg_bytes_setting = '0;

   // transport state
   logic [31:0] status_reg;
   logic [31:0] irq_pending;
   logic [31:0] dev_sel;
   logic [31:0] drv_sel;
   logic [63:0] drv_features;
   logic [31:0] sel_queue;
   logic [31:0] desc_latch  = '0;
   logic [31:0] avail_latch = '0;
   logic [31:0] used_latch  = '0;
   logic [8:0]  q_size  [QUEUE_COUNT];
   logic        q_ready [QUEUE_COUNT];
   logic [63:0] q_desc  [QUEUE_COUNT];
   logic [63:0] q_avail [QUEUE_COUNT];
   logic [63:0] q_used  [QUEUE_COUNT];

   mmio_response_type awaited_responses[$];
   int mismatch_count = 0;
   int item_count = 0;
   int cycle_count = 0;
   int max_gap = 17;

   virtio_mmio_register_block_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_func              (req_func),
      .req_reg_offset        (req_reg_offset),
      .req_access_bytes      (req_access_bytes),
      .req_write_value       (req_write_value),
      .rsp_valid             (rsp_valid),
      .rsp_read_value        (rsp_read_value),
      .rsp_irq_level         (rsp_irq_level),
      .rsp_notify_valid      (rsp_notify_valid),
      .rsp_notify_queue      (rsp_notify_queue),
      .rsp_features_done     (rsp_features_done),
      .rsp_accepted_features (rsp_accepted_features),
      .rsp_reset_pulse       (rsp_reset_pulse),
      .rsp_config_hit        (rsp_config_hit),
      .rsp_config_offset     (rsp_config_offset),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // status write of zero; the address low latches survive it
   function automatic void clear_transport();
      status_reg   = '0;
      irq_pending  = '0;
      dev_sel      = '0;
      drv_sel      = '0;
      drv_features = '0;
      sel_queue    = '0;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
         q_size[i]  = '0;
         q_ready[i] = 1'b0;
         q_desc[i]  = '0;
         q_avail[i] = '0;
         q_used[i]  = '0;
      end
   endfunction

   function automatic void apply_setting(logic [CSR_INDEX_WIDTH-1:0] idx,
                                         logic [CSR_DATA_WIDTH-1:0] data);
      case (idx)
         CSR_DEVICE_TYPE_ID:     type_id_setting   = data[7:0];
         CSR_OFFERED_FEATURES:   feature_offer     = data;
         CSR_VENDOR_CODE:        vendor_setting    = data[31:0];
         CSR_CONFIG_SPACE_BYTES: cfg_bytes_setting = data[8:0];
         default: ;
      endcase
   endfunction

   function automatic mmio_response_type register_access_result(logic [1:0] func_code,
         logic [11:0] offset, logic [3:0] length, logic [31:0] value);
      mmio_response_type r;
      int  csize;
      bit  qok;
      int  q;
      r = '{default: '0};
      csize = (cfg_bytes_setting > CFG_MAX_BYTES) ? int'(CFG_MAX_BYTES) : int'(cfg_bytes_setting);
      qok = sel_queue < QUEUE_COUNT;
      q = qok ? int'(sel_queue) : 0;
      if (func_code == FUNC_READ || func_code == FUNC_WRITE) begin
         if (int'(offset) >= int'(CFG_BASE) && int'(offset) < int'(CFG_BASE) + csize) begin
            r.config_hit    = 1'b1;
            r.config_offset = 8'(offset - CFG_BASE);
         end else if (length == WORD_BYTES && func_code == FUNC_READ) begin
            case (offset)
               OFF_MAGIC:         r.read_value = MAGIC_WORD;
               OFF_VERSION:       r.read_value = VERSION_WORD;
               OFF_DEVICE_ID:     r.read_value = {24'd0, type_id_setting};
               OFF_VENDOR_ID:     r.read_value = vendor_setting;
               OFF_DEV_FEATURES:
                  r.read_value = (dev_sel == 0) ? feature_offer[31:0] :
                                 (dev_sel == 1) ? feature_offer[63:32] : '0;
               OFF_QUEUE_NUM_MAX: r.read_value = qok ? 32'(QUEUE_LIMIT) : '0;
               OFF_QUEUE_READY:   r.read_value = qok ? 32'(q_ready[q]) : '0;
               OFF_IRQ_STATUS:    r.read_value = irq_pending;
               OFF_STATUS:        r.read_value = status_reg;
               default:           r.read_value = '0;
            endcase
         end else if (length == WORD_BYTES) begin
            case (offset)
               OFF_DEV_FEAT_SEL: dev_sel = value;
               OFF_DRV_FEATURES:
                  if (drv_sel == 0) drv_features[31:0] = value;
                  else if (drv_sel == 1) drv_features[63:32] = value;
               OFF_DRV_FEAT_SEL: drv_sel = value;
               OFF_QUEUE_SEL:    sel_queue = value;
               OFF_QUEUE_NUM:
                  if (qok && value <= QUEUE_LIMIT && (value & (value - 1)) == 0)
                     q_size[q] = 9'(value);
               OFF_QUEUE_READY:  if (qok) q_ready[q] = (value != 0);
               OFF_QUEUE_NOTIFY:
                  if (value < QUEUE_COUNT) begin
                     r.notify_valid = 1'b1;
                     r.notify_queue = value[2:0];
                  end
               OFF_IRQ_ACK:      irq_pending &= ~value;
               OFF_STATUS:
                  if (value == 0) begin
                     clear_transport();
                     r.reset_pulse = 1'b1;
                  end else begin
                     status_reg = value;
                     // negotiation completes only while driver_ok is still clear
                     if (value[ST_FEATURES_OK] && !value[ST_DRIVER_OK]) begin
                        r.features_done     = 1'b1;
                        r.accepted_features = drv_features;
                     end
                  end
               OFF_DESC_LOW:   if (qok) desc_latch = value;
               OFF_DESC_HIGH:  if (qok) q_desc[q] = {value, desc_latch};
               OFF_AVAIL_LOW:  if (qok) avail_latch = value;
               OFF_AVAIL_HIGH: if (qok) q_avail[q] = {value, avail_latch};
               OFF_USED_LOW:   if (qok) used_latch = value;
               OFF_USED_HIGH:  if (qok) q_used[q] = {value, used_latch};
               default: ;
            endcase
         end
      end else if (func_code == FUNC_RAISE) begin
         irq_pending |= value;
      end
      r.irq_level = irq_pending != 0;
      return r;
   endfunction

   // requests and setting writes as the block takes them
   always @(posedge clock) begin : predict_response
      mmio_response_type expected;
      if (!reset && start && !busy) begin
         expected = register_access_result(req_func, req_reg_offset,
                                           req_access_bytes, req_write_value);
         awaited_responses = {awaited_responses, expected};
      end
      if (!reset && csr_write_enable)
         apply_setting(csr_index, csr_write_data);
   end

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h actual %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : check_response
      mmio_response_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (awaited_responses.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            want = awaited_responses.pop_front();
            check_field("read_value", want.read_value, rsp_read_value);
            check_field("irq_level", want.irq_level, rsp_irq_level);
            check_field("notify_valid", want.notify_valid, rsp_notify_valid);
            check_field("notify_queue", want.notify_queue, rsp_notify_queue);
            check_field("features_done", want.features_done, rsp_features_done);
            check_field("accepted_features", want.accepted_features, rsp_accepted_features);
            check_field("reset_pulse", want.reset_pulse, rsp_reset_pulse);
            check_field("config_hit", want.config_hit, rsp_config_hit);
            check_field("config_offset", want.config_offset, rsp_config_offset);
         end
      end
   end

   task automatic send_request(input logic [1:0] func_code, input logic [11:0] offset,
                               input logic [3:0] length, input logic [31:0] value);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_func         <= func_code;
      req_reg_offset   <= offset;
      req_access_bytes <= length;
      req_write_value  <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      item_count++;
   endtask

   task automatic bus_write(input logic [11:0] offset, input logic [31:0] value);
      send_request(FUNC_WRITE, offset, WORD_BYTES, value);
   endtask

   task automatic bus_read(input logic [11:0] offset);
      send_request(FUNC_READ, offset, WORD_BYTES, $urandom);
   endtask

   // settings change only once every outstanding request has been answered
   task automatic write_setting(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                input logic [CSR_DATA_WIDTH-1:0] data);
      start <= 1'b0;
      @(posedge clock);
      while (awaited_responses.size() != 0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [11:0] pick_offset();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) return CFG_BASE + 12'($urandom_range(0, 300));
      if (pick < 22) return 12'($urandom);
      case ($urandom_range(0, 21))
         0:  return OFF_MAGIC;
         1:  return OFF_VERSION;
         2:  return OFF_DEVICE_ID;
         3:  return OFF_VENDOR_ID;
         4:  return OFF_DEV_FEATURES;
         5:  return OFF_DEV_FEAT_SEL;
         6:  return OFF_DRV_FEATURES;
         7:  return OFF_DRV_FEAT_SEL;
         8:  return OFF_QUEUE_SEL;
         9:  return OFF_QUEUE_NUM_MAX;
         10: return OFF_QUEUE_NUM;
         11: return OFF_QUEUE_READY;
         12: return OFF_QUEUE_NOTIFY;
         13: return OFF_IRQ_STATUS;
         14: return OFF_IRQ_ACK;
         15: return OFF_STATUS;
         16: return OFF_DESC_LOW;
         17: return OFF_DESC_HIGH;
         18: return OFF_AVAIL_LOW;
         19: return OFF_AVAIL_HIGH;
         20: return OFF_USED_LOW;
         default: return OFF_USED_HIGH;
      endcase
   endfunction

   // mostly sensible values for the selects, sizes and status, anything now and then
   function automatic logic [31:0] pick_write_value(logic [11:0] offset);
      case (offset)
         OFF_DEV_FEAT_SEL, OFF_DRV_FEAT_SEL, OFF_QUEUE_SEL, OFF_QUEUE_NOTIFY:
            return ($urandom_range(0, 3) != 0) ? 32'($urandom_range(0, QUEUE_COUNT)) : $urandom;
         OFF_QUEUE_NUM:
            if ($urandom_range(0, 3) != 0) return 32'(1) << $urandom_range(0, 9);
            else return $urandom_range(0, 1) ? '0 : $urandom;
         OFF_STATUS:
            case ($urandom_range(0, 7))
               0:       return '0;
               1:       return $urandom;
               default: return 32'($urandom_range(1, 15));
            endcase
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_access();
      int pick;
      logic [1:0]  func_code;
      logic [11:0] offset;
      logic [3:0]  length;
      pick = $urandom_range(0, 99);
      func_code = (pick < 45) ? FUNC_WRITE : (pick < 82) ? FUNC_READ :
                  (pick < 92) ? FUNC_RAISE : FUNC_NOP;
      offset = pick_offset();
      length = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 15)) : WORD_BYTES;
      send_request(func_code, offset, length, pick_write_value(offset));
   endtask

   // the order a driver follows to bring the device up, with random content
   task automatic driver_bring_up();
      int last_q;
      if ($urandom_range(0, 3) != 0) bus_write(OFF_STATUS, '0);
      bus_write(OFF_STATUS, STATUS_ACK);
      bus_write(OFF_STATUS, STATUS_ACK | STATUS_DRIVER);
      bus_write(OFF_DEV_FEAT_SEL, 32'd0);
      bus_read(OFF_DEV_FEATURES);
      bus_write(OFF_DEV_FEAT_SEL, 32'd1);
      bus_read(OFF_DEV_FEATURES);
      bus_write(OFF_DRV_FEAT_SEL, 32'd0);
      bus_write(OFF_DRV_FEATURES, $urandom);
      bus_write(OFF_DRV_FEAT_SEL, 32'd1);
      bus_write(OFF_DRV_FEATURES, $urandom);
      bus_write(OFF_STATUS, STATUS_ACK | STATUS_DRIVER | STATUS_FEAT_OK);
      bus_read(OFF_STATUS);
      // sometimes runs one queue past the end
      last_q = $urandom_range(0, QUEUE_COUNT);
      for (int q = 0; q <= last_q; q++) begin
         bus_write(OFF_QUEUE_SEL, 32'(q));
         bus_read(OFF_QUEUE_NUM_MAX);
         bus_write(OFF_QUEUE_NUM, pick_write_value(OFF_QUEUE_NUM));
         bus_write(OFF_DESC_LOW, $urandom);
         bus_write(OFF_DESC_HIGH, $urandom);
         bus_write(OFF_AVAIL_LOW, $urandom);
         bus_write(OFF_AVAIL_HIGH, $urandom);
         bus_write(OFF_USED_LOW, $urandom);
         bus_write(OFF_USED_HIGH, $urandom);
         bus_write(OFF_QUEUE_READY, ($urandom_range(0, 3) != 0) ? $urandom : '0);
         bus_read(OFF_QUEUE_READY);
      end
      bus_write(OFF_STATUS, STATUS_ACK | STATUS_DRIVER | STATUS_FEAT_OK | STATUS_DRV_OK);
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 3))
            0: bus_write(OFF_QUEUE_NOTIFY, 32'($urandom_range(0, QUEUE_COUNT)));
            1: send_request(FUNC_RAISE, 12'($urandom), 4'($urandom),
                            32'(1) << $urandom_range(0, 31));
            2: bus_read(OFF_IRQ_STATUS);
            default: bus_write(OFF_IRQ_ACK, $urandom);
         endcase
      end
   endtask

   task automatic test_identity_registers();
      write_setting(CSR_DEVICE_TYPE_ID, 64'hffff_ffff_ffff_ff5a);
      write_setting(CSR_OFFERED_FEATURES, 64'h8000_0001_7fff_fffe);
      write_setting(CSR_VENDOR_CODE, {32'h1234_5678, ALL_ONES});
      write_setting(CSR_CONFIG_SPACE_BYTES, 64'd8);
      bus_read(OFF_MAGIC);
      bus_read(OFF_VERSION);
      bus_read(OFF_DEVICE_ID);
      send_request(FUNC_READ, OFF_VENDOR_ID, 4'hf, ALL_ONES);
      bus_read(OFF_CONFIG_GEN);
      bus_read(OFF_UNMAPPED);
   endtask

   task automatic test_feature_negotiation();
      bus_write(OFF_DEV_FEAT_SEL, 32'd1);
      bus_read(OFF_DEV_FEATURES);
      bus_write(OFF_DEV_FEAT_SEL, ALL_ONES);
      bus_read(OFF_DEV_FEATURES);
      bus_write(OFF_DRV_FEATURES, ALL_ONES);
      bus_write(OFF_DRV_FEAT_SEL, 32'd1);
      bus_write(OFF_DRV_FEATURES, 32'h8000_0001);
      bus_write(OFF_DRV_FEAT_SEL, 32'd2);
      bus_write(OFF_DRV_FEATURES, '0);
      bus_write(OFF_STATUS, STATUS_FEAT_OK);
      bus_write(OFF_STATUS, STATUS_FEAT_OK | STATUS_DRV_OK);
   endtask

   task automatic test_queue_setup();
      bus_write(OFF_QUEUE_SEL, 32'd1);
      bus_write(OFF_QUEUE_NUM, 32'(QUEUE_LIMIT));
      bus_write(OFF_QUEUE_READY, 32'd5);
      bus_read(OFF_QUEUE_READY);
      bus_write(OFF_QUEUE_SEL, ALL_ONES);
      bus_read(OFF_QUEUE_NUM_MAX);
      bus_read(OFF_QUEUE_READY);
      bus_write(OFF_QUEUE_NOTIFY, 32'd1);
      bus_write(OFF_QUEUE_NOTIFY, 32'(QUEUE_COUNT));
   endtask

   task automatic test_interrupts();
      send_request(FUNC_RAISE, OFF_MAGIC, WORD_BYTES, ALL_ONES);
      bus_write(OFF_IRQ_ACK, 32'h0000_ffff);
      bus_read(OFF_IRQ_STATUS);
      send_request(FUNC_NOP, OFF_STATUS, WORD_BYTES, '0);
      bus_write(OFF_IRQ_ACK, ALL_ONES);
   endtask

   task automatic test_config_space();
      send_request(FUNC_READ, CFG_BASE, 4'd1, '0);
      send_request(FUNC_WRITE, CFG_BASE + 12'h007, 4'd8, ALL_ONES);
      bus_read(CFG_BASE + 12'h008);
      // a size above the window is clipped to 256 bytes
      write_setting(CSR_CONFIG_SPACE_BYTES, 64'h1ff);
      send_request(FUNC_READ, CFG_BASE + 12'h0ff, 4'd0, '0);
      write_setting(CSR_CONFIG_SPACE_BYTES, 64'd0);
      bus_read(CFG_BASE);
   endtask

   task automatic test_device_reset();
      bus_write(OFF_STATUS, '0);
      bus_read(OFF_QUEUE_READY);
      bus_read(OFF_STATUS);
   endtask

   task automatic test_random_traffic(input int items);
      int stop_at;
      stop_at = item_count + items;
      while (item_count < stop_at) begin
         max_gap = ($urandom_range(0, 3) == 0) ? 0 : 17;
         if ($urandom_range(0, 99) < 60) driver_bring_up();
         else repeat ($urandom_range(5, 20)) send_random_access();
      end
   endtask

   task automatic load_settings(input logic [7:0] type_id, input logic [63:0] features,
                                input logic [31:0] vendor, input logic [8:0] cfg_bytes);
      write_setting(CSR_DEVICE_TYPE_ID, {$urandom, $urandom} & ~64'hff | 64'(type_id));
      write_setting(CSR_OFFERED_FEATURES, features);
      write_setting(CSR_VENDOR_CODE, {$urandom, vendor});
      write_setting(CSR_CONFIG_SPACE_BYTES, 64'(cfg_bytes));
   endtask

   initial begin
      int waited;
      clock            = 1'b0;
      reset            = 1'b1;
      start            = 1'b0;
      req_func         = FUNC_NOP;
      req_reg_offset   = '0;
      req_access_bytes = '0;
      req_write_value  = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_DEVICE_TYPE_ID;
      csr_write_data   = '0;
      clear_transport();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_identity_registers();
      test_feature_negotiation();
      test_queue_setup();
      test_interrupts();
      test_config_space();
      test_device_reset();

      load_settings(8'($urandom), {$urandom, $urandom}, $urandom, 9'($urandom_range(0, 300)));
      test_random_traffic(400);
      load_settings('0, '0, '0, '0);
      test_random_traffic(400);
      load_settings(8'hff, {2{ALL_ONES}}, ALL_ONES, 9'h1ff);
      test_random_traffic(400);
      load_settings(8'($urandom), {$urandom, $urandom}, $urandom, CFG_MAX_BYTES);
      test_random_traffic(400);

      start <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (awaited_responses.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (awaited_responses.size() != 0) begin
         $error("%0d requests never answered", awaited_responses.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/vmmio_pkg.sv
hdl/virtio_mmio_register_block_core.sv
tb/tb.sv
